// ----- src/itp_pkg.sv -----
package itp_pkg;

  localparam int unsigned DefStackDepth = 32;
  localparam int unsigned CharW = 8;
  localparam int unsigned PrecW = 4;

  localparam logic [PrecW-1:0] PrecInAdd    = 4'd1;
  localparam logic [PrecW-1:0] PrecInMul    = 4'd3;
  localparam logic [PrecW-1:0] PrecInLetter = 4'd7;
  localparam logic [PrecW-1:0] PrecInClose  = 4'd0;
  localparam logic [PrecW-1:0] PrecInOpen   = 4'd9;

  localparam logic [PrecW-1:0] PrecStkAdd    = 4'd2;
  localparam logic [PrecW-1:0] PrecStkMul    = 4'd4;
  localparam logic [PrecW-1:0] PrecStkLetter = 4'd8;
  localparam logic [PrecW-1:0] PrecStkOpen   = 4'd0;

  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChStar   = 8'h2A;
  localparam logic [CharW-1:0] ChSlash  = 8'h2F;
  localparam logic [CharW-1:0] ChLParen = 8'h28;
  localparam logic [CharW-1:0] ChRParen = 8'h29;
  localparam logic [CharW-1:0] ChLBrack = 8'h5B;
  localparam logic [CharW-1:0] ChRBrack = 8'h5D;
  localparam logic [CharW-1:0] ChLBrace = 8'h7B;
  localparam logic [CharW-1:0] ChRBrace = 8'h7D;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
  localparam logic [CharW-1:0] ChNul    = 8'h00;

  typedef struct packed {
    logic             ok;
    logic [PrecW-1:0] prec;
  } prec_in_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             end_of_expr;
    logic             overflow;
  } result_t;

  typedef struct packed {
    logic gen;
    logic fin;
  } out_ctl_t;

  typedef struct packed {
    logic pend_valid;
    logic can_gen;
    logic can_fin;
  } out_sts_t;

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= ChUpperA) && (c <= ChUpperZ)) || ((c >= ChLowerA) && (c <= ChLowerZ));
  endfunction

  function automatic prec_in_t prec_incoming(input logic [CharW-1:0] c);
    prec_in_t r;
    r.ok = 1'b1;
    if ((c == ChPlus) || (c == ChMinus)) begin
      r.prec = PrecInAdd;
    end else if ((c == ChStar) || (c == ChSlash)) begin
      r.prec = PrecInMul;
    end else if (is_letter(c)) begin
      r.prec = PrecInLetter;
    end else if ((c == ChRParen) || (c == ChRBrack) || (c == ChRBrace)) begin
      r.prec = PrecInClose;
    end else if ((c == ChLParen) || (c == ChLBrack) || (c == ChLBrace)) begin
      r.prec = PrecInOpen;
    end else begin
      r.ok   = 1'b0;
      r.prec = PrecInClose;
    end
    return r;
  endfunction

  function automatic logic [PrecW-1:0] prec_stacked(input logic [CharW-1:0] c);
    logic [PrecW-1:0] r;
    if ((c == ChPlus) || (c == ChMinus)) begin
      r = PrecStkAdd;
    end else if ((c == ChStar) || (c == ChSlash)) begin
      r = PrecStkMul;
    end else if (is_letter(c)) begin
      r = PrecStkLetter;
    end else begin
      r = PrecStkOpen;
    end
    return r;
  endfunction

endpackage

// ----- src/infix_to_postfix_converter.sv -----
// channel  dir  tdata          tlast         tuser
// s_axis   in   in_char        is_last       -
// m_axis   out  out_char       last_of_run   [0] end_of_expr, [1] overflow
//
// each character is taken in idle, then the top of stack is read (rd, cmp) and
// popped while it outranks the character, before the match, drop, push or
// overflow decision; an ignored character skips the stack; flush reads and pops
// each stacked symbol, then emits the end marker; the stack ram read is registered
// reset clears the stack count, overflow flag and the output valid bits
// a stalled output holds the sequencer at the next result it produces
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_char
  input  logic       s_axis_tlast,   // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast,   // last_of_run
  output logic [7:0] m_axis_tuser    // end_of_expr, overflow, zero fill
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRd    = 3'd1;
  localparam logic [2:0] StCmp   = 3'd2;
  localparam logic [2:0] StFlRd  = 3'd3;
  localparam logic [2:0] StFlPop = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic [PrecW-1:0] prec_q, prec_d;

  logic [CntW-1:0]  cnt_m1;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [CharW-1:0] ram_rdata;
  logic             gt, eq;
  prec_in_t         pin;
  out_ctl_t         octl;
  out_sts_t         osts;
  result_t          res;
  logic             s_hs;

  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign pin           = prec_incoming(s_axis_tdata);
  assign cnt_m1        = cnt_q - CntW'(1);
  assign ram_raddr     = cnt_m1[AddrW-1:0];

  itp_ram #(
    .Width (CharW),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (char_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  itp_prec_cmp u_cmp (
    .top_char_i (ram_rdata),
    .empty_i    (cnt_q == '0),
    .prec_in_i  (prec_q),
    .gt_o       (gt),
    .eq_o       (eq)
  );

  itp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (octl),
    .res_i         (res),
    .sts_o         (osts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    char_d   = char_q;
    last_d   = last_q;
    prec_d   = prec_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    octl.gen = 1'b0;
    octl.fin = 1'b0;
    res.out_char    = ram_rdata;
    res.end_of_expr = 1'b0;
    res.overflow    = ovf_q;

    case (state_q)
      StIdle: begin
        if (s_hs) begin
          char_d = s_axis_tdata;
          last_d = s_axis_tlast;
          prec_d = pin.prec;
          if (!pin.ok) begin
            state_d = s_axis_tlast ? StFlRd : StDone;
          end else begin
            state_d = StRd;
          end
        end
      end
      StRd, StCmp: begin
        if ((state_q == StRd) && (cnt_q != '0)) begin
          ram_re  = 1'b1;
          state_d = StCmp;
        end else if (gt) begin
          if (osts.can_gen) begin
            octl.gen = 1'b1;
            cnt_d    = cnt_m1;
            state_d  = StRd;
          end
        end else begin
          // closer meets opener, unmatched closer, push, or overflow on a full stack
          if (eq) begin
            cnt_d = cnt_m1;
          end else if (prec_q == PrecInClose) begin
            cnt_d = cnt_q;
          end else if (cnt_q < CntW'(STACK_DEPTH)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          state_d = last_q ? StFlRd : StDone;
        end
      end
      StFlRd: begin
        if (cnt_q != '0) begin
          ram_re  = 1'b1;
          state_d = StFlPop;
        end else if (osts.can_gen) begin
          octl.gen        = 1'b1;
          res.out_char    = ChNul;
          res.end_of_expr = 1'b1;
          ovf_d           = 1'b0;
          state_d         = StDone;
        end
      end
      StFlPop: begin
        if (osts.can_gen) begin
          octl.gen = 1'b1;
          cnt_d    = cnt_m1;
          state_d  = StFlRd;
        end
      end
      StDone: begin
        if (!osts.pend_valid) begin
          state_d = StIdle;
        end else if (osts.can_fin) begin
          octl.fin = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    prec_q <= prec_d;
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> !s_axis_tready)
    else $error("ready while a character is in work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (octl.gen && res.end_of_expr) |=> (cnt_q == '0 && !ovf_q))
    else $error("state not cleared after end marker");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !osts.pend_valid)
    else $error("idle with a result still held");
`endif

endmodule

// ----- src/itp_ram.sv -----
module itp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/itp_prec_cmp.sv -----
module itp_prec_cmp import itp_pkg::*; (
  input  logic [CharW-1:0] top_char_i,
  input  logic             empty_i,
  input  logic [PrecW-1:0] prec_in_i,
  output logic             gt_o,
  output logic             eq_o
);

  logic [PrecW-1:0] prec_top;

  assign prec_top = prec_stacked(top_char_i);
  // empty stack ranks below every incoming precedence
  assign gt_o = !empty_i && (prec_top > prec_in_i);
  assign eq_o = !empty_i && (prec_top == prec_in_i);

endmodule

// ----- src/itp_out_stage.sv -----
module itp_out_stage import itp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  out_ctl_t   ctl_i,
  input  result_t    res_i,
  output out_sts_t   sts_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast,   // last_of_run
  output logic [7:0] m_axis_tuser    // end_of_expr, overflow, zero fill
);

  logic    pend_valid_q, pend_valid_d;
  result_t pend_q, pend_d;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    out_last_q, out_last_d;
  logic    out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (ctl_i.gen) begin
      // the held result is not the last one of its run
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_d       = res_i;
    end else if (ctl_i.fin) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.can_gen    = !pend_valid_q || out_free;
  assign sts_o.can_fin    = out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_char;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {6'b0, out_q.overflow, out_q.end_of_expr};

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.gen |-> (!pend_valid_q || out_free))
    else $error("result generated while pending slot blocked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fin |-> (pend_valid_q && out_free && !ctl_i.gen))
    else $error("run closed without a pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.end_of_expr) |-> (out_last_q && out_q.out_char == ChNul))
    else $error("end marker malformed");
`endif

endmodule

// ----- dv/infix_to_postfix_converter_checker.sv -----
`timescale 1ns / 1ps

module infix_to_postfix_converter_checker import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,    // in_char
  input  logic        s_tlast_i,    // is_last
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,    // out_char
  input  logic        m_tlast_i,    // last_of_run
  input  logic [7:0]  m_tuser_i,    // end_of_expr, overflow, zero fill
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       eoe;
    logic       run_last;
    logic       ovf;
  } postfix_sym_t;

  postfix_sym_t postfix_q[$];
  logic [7:0]   sym_stack [STACK_DEPTH];
  int           sym_cnt;
  logic         ovf_seen;
  int unsigned  fails;
  postfix_sym_t want;

  function automatic bit letter_char(input logic [7:0] c);
    return ((c >= ChUpperA) && (c <= ChUpperZ)) || ((c >= ChLowerA) && (c <= ChLowerZ));
  endfunction

  // -1 marks a character that is ignored
  function automatic int in_prec(input logic [7:0] c);
    if ((c == ChPlus) || (c == ChMinus)) return 1;
    if ((c == ChStar) || (c == ChSlash)) return 3;
    if (letter_char(c)) return 7;
    if ((c == ChRParen) || (c == ChRBrack) || (c == ChRBrace)) return 0;
    if ((c == ChLParen) || (c == ChLBrack) || (c == ChLBrace)) return 9;
    return -1;
  endfunction

  function automatic int stk_prec(input logic [7:0] c);
    if ((c == ChPlus) || (c == ChMinus)) return 2;
    if ((c == ChStar) || (c == ChSlash)) return 4;
    if (letter_char(c)) return 8;
    return 0;
  endfunction

  function automatic int top_prec();
    if (sym_cnt == 0) return -1;
    return stk_prec(sym_stack[sym_cnt-1]);
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic convert_char(input logic [7:0] c, input logic last);
    postfix_sym_t run[$];
    postfix_sym_t sym;
    int           p;
    logic         ovf_now;
    p = in_prec(c);
    sym = '0;
    if (p >= 0) begin
      while ((sym_cnt > 0) && (top_prec() > p)) begin
        sym.ch = sym_stack[sym_cnt-1];
        run.push_back(sym);
        sym_cnt--;
      end
      // closer meets opener
      if (p == top_prec()) begin
        sym_cnt--;
      end else if (p == 0) begin
        // unmatched closer is dropped
      end else if (sym_cnt < STACK_DEPTH) begin
        sym_stack[sym_cnt] = c;
        sym_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
    ovf_now = ovf_seen;
    if (last) begin
      while (sym_cnt > 0) begin
        sym.ch = sym_stack[sym_cnt-1];
        run.push_back(sym);
        sym_cnt--;
      end
      sym.ch  = ChNul;
      sym.eoe = 1'b1;
      run.push_back(sym);
      ovf_seen = 1'b0;
    end
    for (int k = 0; k < run.size(); k++) begin
      sym          = run[k];
      sym.ovf      = ovf_now;
      sym.run_last = (k == run.size() - 1);
      postfix_q.push_back(sym);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_cnt  = 0;
      ovf_seen = 1'b0;
      fails    = 0;
      postfix_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (postfix_q.size() == 0) begin
          report($sformatf("output transaction %h with nothing pending", m_tdata_i));
        end else begin
          want = postfix_q.pop_front();
          if (m_tdata_i !== want.ch) begin
            report($sformatf("out_char %h, want %h", m_tdata_i, want.ch));
          end
          if (m_tlast_i !== want.run_last) begin
            report($sformatf("last_of_run %b, want %b", m_tlast_i, want.run_last));
          end
          if (m_tuser_i !== {6'b0, want.ovf, want.eoe}) begin
            report($sformatf("tuser %b, want overflow %b end_of_expr %b",
                             m_tuser_i, want.ovf, want.eoe));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        convert_char(s_tdata_i, s_tlast_i);
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= postfix_q.size();
  end

endmodule

// ----- dv/infix_to_postfix_converter_tb.sv -----
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb import itp_pkg::*;;

  localparam int unsigned CycleLimit  = 3000000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned TargetItems = 200;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [7:0] m_axis_tuser;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycle_cnt  = 0;
  int unsigned rx_stall   = 0;
  int unsigned rx_gap;
  int unsigned items_sent = 0;
  int unsigned deep_runs  = 0;
  bit          quiet      = 1'b0;
  logic [7:0]  expr_q[$];

  logic [7:0] ops     [4] = '{ChPlus, ChMinus, ChStar, ChSlash};
  logic [7:0] openers [3] = '{ChLParen, ChLBrack, ChLBrace};
  logic [7:0] closers [3] = '{ChRParen, ChRBrack, ChRBrace};

  infix_to_postfix_converter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  infix_to_postfix_converter_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tlast_i  (m_axis_tlast),
    .m_tuser_i  (m_axis_tuser),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    if (r < 14) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 1) return ChUpperA + 8'($urandom_range(0, 25));
    return ChLowerA + 8'($urandom_range(0, 25));
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output side backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall      <= 0;
    end else if (rx_stall != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall      <= rx_stall - 1;
    end else begin
      rx_gap = pick_gap();
      if (rx_gap == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_stall      <= rx_gap - 1;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) begin
      send_char(expr_q[i], i == expr_q.size() - 1);
    end
    expr_q.delete();
  endtask

  task automatic add_sym(input logic [7:0] c);
    expr_q.push_back(c);
    items_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_sym(s[i]);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic build_well_formed();
    int unsigned depth;
    int unsigned len;
    int unsigned max_len;
    bit          want_operand;
    depth        = 0;
    len          = 0;
    max_len      = $urandom_range(1, 20);
    want_operand = 1'b1;
    forever begin
      if ($urandom_range(0, 15) == 0) expr_q.push_back(8'($urandom_range(0, 255)));
      if (want_operand) begin
        if ((depth < 6) && ($urandom_range(0, 3) == 0)) begin
          add_sym(openers[$urandom_range(0, 2)]);
          depth++;
        end else begin
          add_sym(rand_letter());
          want_operand = 1'b0;
          len++;
        end
      end else if (len >= max_len) begin
        while (depth > 0) begin
          add_sym(closers[$urandom_range(0, 2)]);
          depth--;
        end
        break;
      end else if ((depth > 0) && ($urandom_range(0, 3) == 0)) begin
        add_sym(closers[$urandom_range(0, 2)]);
        depth--;
      end else begin
        add_sym(ops[$urandom_range(0, 3)]);
        want_operand = 1'b1;
      end
    end
  endtask

  // nesting up to and past the stack depth
  task automatic build_deep();
    int unsigned n;
    n = $urandom_range(30, 40);
    repeat (n) add_sym(openers[$urandom_range(0, 2)]);
    add_sym(rand_letter());
    add_sym(ops[$urandom_range(0, 3)]);
    add_sym(rand_letter());
    deep_runs++;
  endtask

  task automatic build_broken();
    int unsigned n;
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: add_sym(rand_letter());
        1: add_sym(ops[$urandom_range(0, 3)]);
        2: add_sym(openers[$urandom_range(0, 2)]);
        default: add_sym(closers[$urandom_range(0, 2)]);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // letter extremes, every operator, parentheses
    add_text("A+z*(Z-a)/B");
    send_expr();
    // mixed bracket kinds, unmatched closer, ignored characters, ignored last
    add_text("[x+y})");
    expr_q.push_back(ChNul);
    expr_q.push_back(8'hFF);
    expr_q.push_back(8'h40);
    expr_q.push_back(8'h60);
    add_text("{q]");
    expr_q.push_back(8'h7E);
    send_expr();
    wait_drained();

    items_sent = 0;
    while (items_sent < TargetItems) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (deep_runs == 0) begin
        build_deep();
      end else begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(0, 255)));
          1: build_broken();
          2: if (deep_runs < 2) build_deep(); else build_well_formed();
          default: build_well_formed();
        endcase
      end
      send_expr();
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    quiet = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if ((fail_cnt == 0) && (pending == 0)) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
